>>> hw/rtl/thsa_pkg.sv
// thsa_pkg: field widths, operation and status codes, register indexes and
// reset values for the tagged handle slot allocator.
// No dependencies.
package thsa_pkg;

    // field widths of the channels
    localparam int OP_W        = 2;
    localparam int TAG_W       = 8;
    localparam int IDX_FIELD_W = 24;
    localparam int HANDLE_W    = TAG_W + IDX_FIELD_W;
    localparam int PAYLOAD_W   = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 9;

    // configuration port widths
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;

    // default slot table depth
    localparam int DEF_MAX_SLOTS = 256;

    // register reset values
    localparam logic [TAG_W-1:0]   MAGIC_TAG_RESET  = '0;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = COUNT_W'(256);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_TAG  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT = CFG_INDEX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_ATTACH  = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NONE_FREE = 3'd1,
        ST_BAD_TAG   = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

endpackage

>>> hw/rtl/thsa_if.sv
// thsa_if: valid/ready channel interfaces of the slot allocator
// (configuration writes, requests, responses).
// Depends on thsa_pkg.

// configuration write channel
interface thsa_cfg_if import thsa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// request channel
interface thsa_req_if import thsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, op, handle, payload, input ready);
    modport sink   (input valid, op, handle, payload, output ready);
endinterface

// response channel
interface thsa_rsp_if import thsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [HANDLE_W-1:0]  new_handle;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COUNT_W-1:0]   in_use_count;

    modport source (output valid, status, new_handle, payload_out, in_use_count, input ready);
    modport sink   (input valid, status, new_handle, payload_out, in_use_count, output ready);
endinterface

>>> hw/rtl/tagged_handle_slot_allocator.sv
// tagged_handle_slot_allocator: FIFO slot allocator for tagged 32-bit handles,
// built around slot, occupancy and freed-index memories.
// Depends on thsa_pkg and the channel interfaces in thsa_if.

// Each request has a transfer and an execute cycle: the transfer issues reads
// of the occupancy, payload and freed-index memories into registered read data,
// and the read-modify-write and write-back happen in the execute cycle. The next
// request transfer can follow in the cycle after the write-back, and no request
// is taken during an execute cycle. The response sits in an output
// register; a new request is taken while it waits only in the cycle in which
// that response transfers, so a stalled response stalls the request side too.
// After reset and after each configuration write
// to a defined register, a clearing pass over all MAX_SLOTS entries wipes the
// occupancy memory; no request is taken during it.
module tagged_handle_slot_allocator import thsa_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic       clk,
    input  logic       rst_n,
    thsa_cfg_if.sink   cfg,
    thsa_req_if.sink   req,
    thsa_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int FW    = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_SLOTS - 1);

    // configuration registers
    logic [TAG_W-1:0]   magic_tag_reg;
    logic [COUNT_W-1:0] slot_count_reg;

    // allocator control state
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             busy_reg;
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    // request held for the execute cycle
    op_t                  op_reg;
    logic [HANDLE_W-1:0]  handle_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    // memories and their registered read data
    logic                 occ_mem   [MAX_SLOTS];
    logic [PAYLOAD_W-1:0] entry_mem [MAX_SLOTS];
    logic [IDX_W-1:0]     queue_mem [MAX_SLOTS];
    logic                 occ_rd_reg;
    logic [PAYLOAD_W-1:0] entry_rd_reg;
    logic [IDX_W-1:0]     queue_rd_reg;

    // output register
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [HANDLE_W-1:0]  new_handle_reg;
    logic [PAYLOAD_W-1:0] payload_out_reg;
    logic [COUNT_W-1:0]   in_use_reg;

    logic cfg_fire;
    logic cfg_hit;
    logic req_fire;
    logic rsp_fire;
    logic [IDX_W-1:0] rd_addr;

    // execute-cycle results
    logic [CNT_W-1:0]       n_eff;
    logic [TAG_W-1:0]       tag_in;
    logic [IDX_FIELD_W-1:0] idx_in;
    logic [IDX_W-1:0]       slot;
    logic                   in_range;
    status_t                status_c;
    logic [CNT_W-1:0]       got;
    logic [HANDLE_W-1:0]    new_handle_c;
    logic [PAYLOAD_W-1:0]   payload_out_c;
    logic                   entry_we;
    logic                   occ_we;
    logic                   occ_wd;
    logic                   queue_we;
    logic [FW-1:0]          fresh_left;
    logic [FW-1:0]          free_cnt;
    logic [FW-1:0]          in_use_w;

    // handshakes
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_fire && (cfg.index == CFG_MAGIC_TAG || cfg.index == CFG_SLOT_COUNT);
    assign req.ready = !clr_active_reg && !busy_reg && !cfg.valid
                       && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = out_valid_reg && rsp.ready;

    // slot address of the incoming handle
    assign rd_addr = IDX_W'(req.handle[IDX_FIELD_W-1:0] - IDX_FIELD_W'(1));

    // effective slot count, clamped to one through MAX_SLOTS
    always_comb
    begin
        if (slot_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (32'(slot_count_reg) > 32'(MAX_SLOTS))
            n_eff = CNT_W'(MAX_SLOTS);
        else
            n_eff = CNT_W'(slot_count_reg);
    end

    assign tag_in   = handle_reg[HANDLE_W-1:IDX_FIELD_W];
    assign idx_in   = handle_reg[IDX_FIELD_W-1:0];
    assign slot     = IDX_W'(idx_in - IDX_FIELD_W'(1));
    assign in_range = (idx_in != '0) && (32'(idx_in) <= 32'(n_eff));

    // read-modify-write decision of the execute cycle
    always_comb
    begin
        status_c      = ST_OK;
        got           = '0;
        new_handle_c  = '0;
        payload_out_c = '0;
        fresh_next    = fresh_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        entry_we      = 1'b0;
        occ_we        = 1'b0;
        occ_wd        = 1'b0;
        queue_we      = 1'b0;
        unique case (op_reg) inside
            OP_ALLOC:
            begin
                if (fresh_reg <= n_eff)
                begin
                    got        = fresh_reg;
                    fresh_next = fresh_reg + CNT_W'(1);
                end
                else if (fill_reg != '0)
                begin
                    got       = CNT_W'(queue_rd_reg) + CNT_W'(1);
                    head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + IDX_W'(1);
                    fill_next = fill_reg - CNT_W'(1);
                end
                else
                begin
                    status_c = ST_NONE_FREE;
                end
                if (status_c == ST_OK)
                    new_handle_c = {magic_tag_reg, IDX_FIELD_W'(got)};
            end
            OP_ATTACH, OP_LOOKUP, OP_RELEASE:
            begin
                if (tag_in != magic_tag_reg)
                    status_c = ST_BAD_TAG;
                else if (!in_range)
                    status_c = ST_RANGE;
                else
                begin
                    case (op_reg)
                        OP_ATTACH:
                        begin
                            if (occ_rd_reg)
                                status_c = ST_FULL;
                            else
                            begin
                                entry_we = 1'b1;
                                occ_we   = 1'b1;
                                occ_wd   = 1'b1;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (!occ_rd_reg)
                                status_c = ST_EMPTY;
                            else
                                payload_out_c = entry_rd_reg;
                        end
                        default:
                        begin
                            if (!occ_rd_reg)
                                status_c = ST_EMPTY;
                            else
                            begin
                                occ_we = 1'b1;
                                occ_wd = 1'b0;
                                // a full queue drops the index
                                if (32'(fill_reg) < 32'(MAX_SLOTS))
                                begin
                                    queue_we  = 1'b1;
                                    tail_next = (tail_reg == LAST_SLOT) ?
                                                '0 : tail_reg + IDX_W'(1);
                                    fill_next = fill_reg + CNT_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // slots in use after this item
    always_comb
    begin
        fresh_left = (fresh_next <= n_eff) ?
                     FW'(n_eff) + FW'(1) - FW'(fresh_next) : '0;
        free_cnt   = fresh_left + FW'(fill_next);
        in_use_w   = (free_cnt >= FW'(n_eff)) ? '0 : FW'(n_eff) - free_cnt;
    end

    // configuration registers and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_tag_reg  <= MAGIC_TAG_RESET;
            slot_count_reg <= SLOT_COUNT_RESET;
            fresh_reg      <= CNT_W'(1);
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            busy_reg       <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (cfg_hit)
            begin
                if (cfg.index == CFG_MAGIC_TAG)
                    magic_tag_reg <= cfg.data[TAG_W-1:0];
                else
                    slot_count_reg <= cfg.data[COUNT_W-1:0];
                fresh_reg      <= CNT_W'(1);
                head_reg       <= '0;
                tail_reg       <= '0;
                fill_reg       <= '0;
                clr_active_reg <= 1'b1;
                clr_addr_reg   <= '0;
            end
            else
            begin
                if (busy_reg)
                begin
                    fresh_reg <= fresh_next;
                    head_reg  <= head_next;
                    tail_reg  <= tail_next;
                    fill_reg  <= fill_next;
                end
                // clearing pass over the occupancy memory
                if (clr_active_reg)
                begin
                    if (clr_addr_reg == LAST_SLOT)
                        clr_active_reg <= 1'b0;
                    clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                end
            end
            busy_reg <= req_fire;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= req.op;
            handle_reg  <= req.handle;
            payload_reg <= req.payload;
        end
    end

    // occupancy memory: clearing pass or execute write-back
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            occ_mem[clr_addr_reg] <= 1'b0;
        else if (busy_reg && occ_we)
            occ_mem[slot] <= occ_wd;
        if (req_fire)
            occ_rd_reg <= occ_mem[rd_addr];
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (busy_reg && entry_we)
            entry_mem[slot] <= payload_reg;
        if (req_fire)
            entry_rd_reg <= entry_mem[rd_addr];
    end

    // freed-index queue memory
    always_ff @(posedge clk)
    begin
        if (busy_reg && queue_we)
            queue_mem[tail_reg] <= slot;
        if (req_fire)
            queue_rd_reg <= queue_mem[head_reg];
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (busy_reg)
            out_valid_reg <= 1'b1;
        else if (rsp_fire)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            status_reg      <= status_c;
            new_handle_reg  <= new_handle_c;
            payload_out_reg <= payload_out_c;
            in_use_reg      <= COUNT_W'(in_use_w);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.new_handle   = new_handle_reg;
    assign rsp.payload_out  = payload_out_reg;
    assign rsp.in_use_count = in_use_reg;

    // the execute cycle always finds the output register free
    a_out_free_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !out_valid_reg)
        else $error("execute cycle with a response still pending");

    // freed-index count never exceeds the queue depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(MAX_SLOTS))
        else $error("freed-index count beyond queue depth");

    // the fresh index never runs past one beyond the effective count
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= n_eff + CNT_W'(1) && fresh_reg != '0)
        else $error("fresh index out of bounds");

    // no request is in execution while the clearing pass runs
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_active_reg && busy_reg))
        else $error("request executed during clearing pass");

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench of the tagged handle slot allocator
// drives requests and register writes, predicts every reply and compares it.
// Depends on thsa_pkg, the channel interfaces in thsa_if and the allocator RTL.
module tb_top;
    import thsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = DEF_MAX_SLOTS;
    localparam int RUN_LIMIT   = 700000;
    localparam int PEND_DEPTH  = 16;
    localparam int ISSUE_KEEP  = 48;
    localparam int ORDER_SLOTS = 32;

    typedef struct packed {
        status_t              status;
        logic [HANDLE_W-1:0]  new_handle;
        logic [PAYLOAD_W-1:0] payload_out;
        logic [COUNT_W-1:0]   in_use_count;
    } slot_reply_t;

    logic clk;
    logic rst_n;

    thsa_cfg_if cfg_bus ();
    thsa_req_if req_bus ();
    thsa_rsp_if rsp_bus ();

    tagged_handle_slot_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // predicted allocator state
    logic [TAG_W-1:0]     cur_tag;
    logic [COUNT_W-1:0]   cur_count;
    logic [PAYLOAD_W-1:0] stored_word [SLOTS];
    logic                 slot_busy [SLOTS];
    int                   recycle_ring [SLOTS];
    int                   next_fresh;
    int                   ring_head;
    int                   ring_tail;
    int                   ring_fill;

    // expected replies in flight, written by the sender, read by the checker
    slot_reply_t pend_ring [PEND_DEPTH];
    int          pend_pushed = 0;
    int          pend_popped = 0;

    // recently issued indices for the random traffic
    int          issued_ring [ISSUE_KEEP];
    int          issued_wr;
    int          issued_count;

    // run bookkeeping
    int          sent_items  = 0;
    int          reply_count = 0;
    int          cfg_writes  = 0;
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles, %0d replies still pending",
                 cycle_count, pend_pushed - pend_popped);
        $display("tagged_handle_slot_allocator test failed");
        $finish;
    end

    function automatic int usable_slots();
        if (cur_count == '0)
            return 1;
        if (int'(cur_count) > SLOTS)
            return SLOTS;
        return int'(cur_count);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // keep the last few handed-out indices
    function automatic void remember_index(int idx);
        issued_ring[issued_wr] = idx;
        issued_wr = (issued_wr + 1) % ISSUE_KEEP;
        if (issued_count < ISSUE_KEEP)
            issued_count++;
    endfunction

    // occupancy, fresh pointer, freed ring and issued-index list go back to empty
    task automatic clear_tables();
        for (int i = 0; i < SLOTS; i++)
            slot_busy[i] = 1'b0;
        next_fresh   = 1;
        ring_head    = 0;
        ring_tail    = 0;
        ring_fill    = 0;
        issued_wr    = 0;
        issued_count = 0;
    endtask

    // one request applied to the predicted state
    function automatic slot_reply_t predict_slot_op(op_t op, logic [HANDLE_W-1:0] handle,
                                                    logic [PAYLOAD_W-1:0] payload);
        slot_reply_t r;
        int          n;
        int          idx;
        int          got;
        int          slot;
        int          fresh_left;
        int          free_cnt;
        r.status       = ST_OK;
        r.new_handle   = '0;
        r.payload_out  = '0;
        r.in_use_count = '0;
        n   = usable_slots();
        idx = int'(handle[IDX_FIELD_W-1:0]);
        got = 0;
        if (op == OP_ALLOC)
        begin
            // fresh indices first, then recycled ones in release order
            if (next_fresh <= n)
            begin
                got = next_fresh;
                next_fresh++;
            end
            else if (ring_fill > 0)
            begin
                got       = recycle_ring[ring_head] + 1;
                ring_head = (ring_head + 1) % SLOTS;
                ring_fill--;
            end
            else
                r.status = ST_NONE_FREE;
            if (r.status == ST_OK)
                r.new_handle = {cur_tag, IDX_FIELD_W'(got)};
        end
        else if (handle[HANDLE_W-1 -: TAG_W] != cur_tag)
            r.status = ST_BAD_TAG;
        else if (idx == 0 || idx > n)
            r.status = ST_RANGE;
        else
        begin
            slot = idx - 1;
            case (op)
                OP_ATTACH:
                begin
                    if (slot_busy[slot])
                        r.status = ST_FULL;
                    else
                    begin
                        stored_word[slot] = payload;
                        slot_busy[slot]   = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (!slot_busy[slot])
                        r.status = ST_EMPTY;
                    else
                        r.payload_out = stored_word[slot];
                end
                default:
                begin
                    // release: a full ring drops the index
                    if (!slot_busy[slot])
                        r.status = ST_EMPTY;
                    else
                    begin
                        slot_busy[slot] = 1'b0;
                        if (ring_fill < SLOTS)
                        begin
                            recycle_ring[ring_tail] = slot;
                            ring_tail = (ring_tail + 1) % SLOTS;
                            ring_fill++;
                        end
                    end
                end
            endcase
        end
        fresh_left = (next_fresh <= n) ? (n + 1 - next_fresh) : 0;
        free_cnt   = fresh_left + ring_fill;
        r.in_use_count = COUNT_W'((free_cnt >= n) ? 0 : (n - free_cnt));
        return r;
    endfunction

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    // request transfer with a random gap in front
    task automatic send_req(op_t op, logic [HANDLE_W-1:0] handle,
                            logic [PAYLOAD_W-1:0] payload);
        int          gap;
        slot_reply_t want;
        gap = (sent_items % 128 < 24) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.op      <= op;
        req_bus.handle  <= handle;
        req_bus.payload <= payload;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        want = predict_slot_op(op, handle, payload);
        pend_ring[pend_pushed % PEND_DEPTH] = want;
        pend_pushed++;
        sent_items++;
        if (op == OP_ALLOC && want.status == ST_OK)
            remember_index(int'(want.new_handle[IDX_FIELD_W-1:0]));
    endtask

    // sender holds off until every reply is back
    task automatic drain_replies(int tail);
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pend_pushed != pend_popped)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // register write, only with the allocator idle
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        drain_replies(0);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        cfg_writes++;
        if (index == CFG_MAGIC_TAG)
        begin
            cur_tag = data[TAG_W-1:0];
            clear_tables();
        end
        else if (index == CFG_SLOT_COUNT)
        begin
            cur_count = data;
            clear_tables();
        end
    endtask

    // reply checker with random back-pressure
    initial
    begin
        slot_reply_t want;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                if (pend_pushed == pend_popped)
                    note_failure($sformatf("reply with nothing pending, status %0d",
                                           rsp_bus.status));
                else
                begin
                    want = pend_ring[pend_popped % PEND_DEPTH];
                    pend_popped++;
                    if (rsp_bus.status !== want.status)
                        note_failure($sformatf("reply %0d status: expected %0d, got %0d",
                                               reply_count, want.status, rsp_bus.status));
                    if (rsp_bus.new_handle !== want.new_handle)
                        note_failure($sformatf("reply %0d new_handle: expected %h, got %h",
                                               reply_count, want.new_handle,
                                               rsp_bus.new_handle));
                    if (rsp_bus.payload_out !== want.payload_out)
                        note_failure($sformatf("reply %0d payload_out: expected %h, got %h",
                                               reply_count, want.payload_out,
                                               rsp_bus.payload_out));
                    if (rsp_bus.in_use_count !== want.in_use_count)
                        note_failure($sformatf("reply %0d in_use_count: expected %0d, got %0d",
                                               reply_count, want.in_use_count,
                                               rsp_bus.in_use_count));
                end
                reply_count++;
            end
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (cycle_count % 1000 >= 150 && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // reset values: default tag and the full table
    task automatic test_defaults();
        send_req(OP_ALLOC, 32'hA5FF_FFFF, 32'h1234_5678);
        send_req(OP_LOOKUP, 32'h0000_0001, '0);
        send_req(OP_ATTACH, 32'h0000_0100, 32'hFFFF_FFFF);
        send_req(OP_LOOKUP, 32'h0000_0100, '0);
        send_req(OP_ATTACH, 32'h0000_0100, 32'h0);
        send_req(OP_RELEASE, 32'h0000_0101, '0);
        send_req(OP_LOOKUP, 32'h00FF_FFFF, '0);
    endtask

    // four slots: exhaustion, every status code, check order, recycling
    task automatic test_small_table();
        write_reg(CFG_MAGIC_TAG, CFG_DATA_W'(8'hFF));
        write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(4));
        repeat (5) send_req(OP_ALLOC, $urandom, $urandom);
        send_req(OP_ATTACH, 32'hFF00_0002, 32'hFFFF_FFFF);
        send_req(OP_ATTACH, 32'hFF00_0002, 32'h0BAD_F00D);
        send_req(OP_LOOKUP, 32'hFF00_0002, '0);
        send_req(OP_LOOKUP, 32'hFF00_0003, '0);
        send_req(OP_ATTACH, 32'h7E00_0002, 32'h1);
        send_req(OP_LOOKUP, 32'h0000_0000, '0);
        send_req(OP_RELEASE, 32'hFF00_0000, '0);
        send_req(OP_RELEASE, 32'hFF00_0005, '0);
        send_req(OP_RELEASE, 32'hFF00_0002, '0);
        send_req(OP_RELEASE, 32'hFF00_0002, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_LOOKUP, 32'hFF00_0002, '0);
        send_req(OP_ATTACH, 32'hFF00_0004, 32'h0);
        send_req(OP_RELEASE, 32'hFF00_0004, '0);
        send_req(OP_ALLOC, '1, '1);
    endtask

    // clamped counts and writes to indices outside the register list
    task automatic test_register_edges();
        write_reg(CFG_MAGIC_TAG, CFG_DATA_W'(8'h00));
        write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(0));
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ATTACH, 32'h0000_0001, 32'hC001_D00D);
        write_reg(CFG_INDEX_W'(8'hFF), 9'h1FF);
        write_reg(CFG_INDEX_W'($urandom_range(2, 254)), CFG_DATA_W'($urandom));
        send_req(OP_LOOKUP, 32'h0000_0001, '0);
        send_req(OP_RELEASE, 32'h0000_0001, '0);
        send_req(OP_ALLOC, '0, '0);
        send_req(OP_ALLOC, '0, '0);
        write_reg(CFG_SLOT_COUNT, 9'h1FF);
        send_req(OP_ATTACH, 32'h0000_0100, 32'h8000_0001);
        send_req(OP_LOOKUP, 32'h0000_0100, '0);
        send_req(OP_ATTACH, 32'h0000_0101, 32'h0);
    endtask

    // use every slot of a small table, release in scrambled order, reallocate
    task automatic test_release_order();
        write_reg(CFG_MAGIC_TAG, CFG_DATA_W'(8'h5A));
        write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(ORDER_SLOTS));
        for (int i = 1; i <= ORDER_SLOTS; i++)
            send_req(OP_ALLOC, $urandom, $urandom);
        for (int i = 1; i <= ORDER_SLOTS; i++)
            send_req(OP_ATTACH, {8'h5A, IDX_FIELD_W'(i)}, $urandom);
        for (int i = 1; i <= ORDER_SLOTS; i++)
            send_req(OP_RELEASE, {8'h5A, IDX_FIELD_W'((i * 37) % ORDER_SLOTS + 1)}, '0);
        send_req(OP_ATTACH, 32'h5A00_0007, 32'h7777_7777);
        send_req(OP_RELEASE, 32'h5A00_0007, '0);
        for (int i = 0; i <= ORDER_SLOTS + 1; i++)
            send_req(OP_ALLOC, '0, '0);
    endtask

    // random traffic, mostly valid handles, over several table settings
    task automatic test_random_traffic();
        int         n;
        int         r;
        int         k;
        int         idx;
        logic [7:0] tag;
        op_t        op;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_MAGIC_TAG, CFG_DATA_W'($urandom));
            case (phase)
                0: write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(3));
                1: write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(8));
                2: write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(1));
                3: write_reg(CFG_SLOT_COUNT, CFG_DATA_W'($urandom_range(2, 40)));
                4: write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(SLOTS));
                default: write_reg(CFG_SLOT_COUNT, CFG_DATA_W'($urandom_range(257, 511)));
            endcase
            for (int item = 0; item < 40; item++)
            begin
                n = usable_slots();
                r = $urandom_range(0, 99);
                if (r < 30)
                    op = OP_ALLOC;
                else if (r < 55)
                    op = OP_ATTACH;
                else if (r < 78)
                    op = OP_LOOKUP;
                else
                    op = OP_RELEASE;
                tag = ($urandom_range(0, 99) < 90) ? cur_tag : 8'($urandom);
                k = $urandom_range(0, 99);
                if (k < 60 && issued_count > 0)
                    idx = issued_ring[$urandom_range(0, issued_count - 1)];
                else if (k < 90)
                    idx = $urandom_range(1, n);
                else if (k < 95)
                    idx = ($urandom_range(0, 1) == 0) ? 0 : n + 1;
                else
                    idx = int'($urandom & 32'h00FF_FFFF);
                if (op == OP_ALLOC)
                    send_req(op, $urandom, $urandom);
                else
                    send_req(op, {tag, IDX_FIELD_W'(idx)}, $urandom);
                // hold the sender once per phase until all replies are in
                if (item == 20)
                    drain_replies(0);
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        rst_n           <= 1'b0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= '0;
        cfg_bus.data    <= '0;
        req_bus.valid   <= 1'b0;
        req_bus.op      <= OP_ALLOC;
        req_bus.handle  <= '0;
        req_bus.payload <= '0;
        cur_tag     = MAGIC_TAG_RESET;
        cur_count   = SLOT_COUNT_RESET;
        clear_tables();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_small_table();
        test_register_edges();
        test_release_order();
        test_random_traffic();
        drain_replies(10);

        $display("%0d requests and %0d register writes sent, %0d replies checked",
                 sent_items, cfg_writes, reply_count);
        $display("covered all ops and status codes, clamped counts, release-order reuse, %0d errors",
                 mismatches);
        if (mismatches == 0)
            $display("tagged_handle_slot_allocator test passed");
        else
            $display("tagged_handle_slot_allocator test failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/thsa_pkg.sv
hw/rtl/thsa_if.sv
hw/rtl/tagged_handle_slot_allocator.sv
sim/tb_top.sv
